### rtl/plcl_pkg.sv
// Shared types, status codes and sizes for the calibration lookup.
package plcl_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int FREQ_W = 40;
  localparam int CORR_W = 32;
  localparam int UNC_W = 31;
  localparam int ROW_W = FREQ_W + CORR_W + UNC_W;
  localparam int IDX_W = 5;
  localparam int CFG_W = 6;
  localparam int STAT_W = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_EXTRAP_EN = 1'b1;

  localparam logic [STAT_W-1:0] ST_LOAD_OK = 3'd0;
  localparam logic [STAT_W-1:0] ST_APPLIED = 3'd1;
  localparam logic [STAT_W-1:0] ST_INTERP = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXTRAP = 3'd3;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd4;
  localparam logic [STAT_W-1:0] ST_LOAD_REJ = 3'd5;

  // One queued item, already classified by the front end.
  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  idx;
    logic [FREQ_W-1:0] pf;
    logic [CORR_W-1:0] pc;
    logic [UNC_W-1:0]  pu;
    logic [FREQ_W-1:0] qf;
    logic              last;
    logic              early;   // load rejected or query invalid without table access
  } item_t;

endpackage

### rtl/plcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/plcl_front.sv
// Front end: classify incoming items and push them into the queue.
module plcl_front #(
  parameter int MAX_POINTS = plcl_pkg::MAX_POINTS_DEF
) (
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        op,
  input  logic [plcl_pkg::IDX_W-1:0]  point_index,
  input  logic [plcl_pkg::FREQ_W-1:0] point_frequency,
  input  logic [plcl_pkg::CORR_W-1:0] point_correction,
  input  logic [plcl_pkg::UNC_W-1:0]  point_uncertainty,
  input  logic [plcl_pkg::FREQ_W-1:0] query_frequency,
  input  logic                        grid_last,
  input  logic                        q_full,
  output logic                        push,
  output plcl_pkg::item_t             push_item
);
  import plcl_pkg::*;

  logic idx_bad;

  assign idx_bad = (32'(point_index) >= 32'(MAX_POINTS));
  assign item_stall = q_full;
  assign push = item_valid && !q_full;

  always_comb begin
    push_item.op = op;
    push_item.idx = point_index;
    push_item.pf = point_frequency;
    push_item.pc = point_correction;
    push_item.pu = point_uncertainty;
    push_item.qf = query_frequency;
    push_item.last = grid_last;
    if (op == OP_LOAD) begin
      push_item.early = idx_bad || (point_frequency == '0);
    end else begin
      push_item.early = (query_frequency == '0);
    end
  end
endmodule

### rtl/plcl_queue.sv
// Two-entry item queue between front end and back end.
module plcl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  plcl_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output plcl_pkg::item_t head
);
  import plcl_pkg::*;

  item_t slots [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### rtl/plcl_muldiv.sv
// Shift-add multiply, restoring divide and rounding for one interpolated value.
module plcl_muldiv (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                a_neg,
  input  logic [39:0]         am,
  input  logic signed [31:0]  vl,
  input  logic signed [31:0]  vr,
  input  logic [39:0]         d,
  output logic                done,
  output logic signed [31:0]  res
);
  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_MUL  = 5'b00010,
    M_DIV  = 5'b00100,
    M_RND  = 5'b01000,
    M_FIN  = 5'b10000
  } mstate_t;

  mstate_t st;
  logic [6:0]  cnt;
  logic        neg, sat;
  logic [39:0] a_r, d_r, hi, rem;
  logic [31:0] lo, vl_r;
  logic [71:0] quo;
  logic [40:0] mag;
  logic [32:0] b;
  logic [40:0] sum, remsh;
  logic [72:0] mag_full;
  logic        rbit;
  logic signed [41:0] tot;

  assign b = {vr[31], vr} - {vl[31], vl};
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : 41'd0);
  assign remsh = {rem, quo[71]};
  assign rbit = ({rem, 1'b0} >= {1'b0, d_r});
  assign mag_full = {1'b0, quo} + 73'(rbit);
  assign tot = neg ? ($signed({{10{vl_r[31]}}, vl_r}) - $signed({1'b0, mag}))
                   : ($signed({{10{vl_r[31]}}, vl_r}) + $signed({1'b0, mag}));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == M_FIN);
      unique case (st)
        M_IDLE: begin
          if (start) begin
            neg <= a_neg ^ b[32];
            a_r <= am;
            d_r <= d;
            vl_r <= vl;
            hi <= '0;
            lo <= b[32] ? 32'(-b) : b[31:0];
            cnt <= '0;
            st <= M_MUL;
          end
        end
        M_MUL: begin
          hi <= sum[40:1];
          lo <= {sum[0], lo[31:1]};
          if (cnt == 7'd31) begin
            quo <= {sum[40:1], sum[0], lo[31:1]};
            rem <= '0;
            cnt <= '0;
            st <= M_DIV;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        M_DIV: begin
          if (remsh >= {1'b0, d_r}) begin
            rem <= 40'(remsh - {1'b0, d_r});
            quo <= {quo[70:0], 1'b1};
          end else begin
            rem <= remsh[39:0];
            quo <= {quo[70:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd71) begin
            st <= M_RND;
          end
        end
        M_RND: begin
          sat <= (mag_full > (73'd1 << 40));
          mag <= mag_full[40:0];
          st <= M_FIN;
        end
        M_FIN: begin
          if (sat) begin
            res <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else if (tot > 42'sd2147483647) begin
            res <= 32'sh7fff_ffff;
          end else if (tot < -42'sd2147483648) begin
            res <= 32'sh8000_0000;
          end else begin
            res <= tot[31:0];
          end
          st <= M_IDLE;
        end
        default: st <= M_IDLE;
      endcase
    end
  end
endmodule

### rtl/plcl_back.sv
// Back end: table access, search, arithmetic sequencing and result register.
module plcl_back #(
  parameter int MAX_POINTS = plcl_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [plcl_pkg::CFG_W-1:0]  point_count,
  input  logic                        extrap_en,
  input  logic                        q_empty,
  input  plcl_pkg::item_t             head,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [31:0]                 correction,
  output logic [31:0]                 uncertainty,
  output logic [plcl_pkg::STAT_W-1:0] sample_status,
  output logic [plcl_pkg::STAT_W-1:0] grid_worst_status,
  output logic                        grid_end
);
  import plcl_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LCHK  = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_RDL   = 9'b000010000,
    S_RDR   = 9'b000100000,
    S_PAIR  = 9'b001000000,
    S_ARITH = 9'b010000000,
    S_OUT   = 9'b100000000
  } bstate_t;

  bstate_t st;
  item_t cur;
  logic [CNT_W-1:0] i, n;
  logic [ADDR_W-1:0] l, raddr;
  logic we;
  logic [ROW_W-1:0] rdata;
  logic [FREQ_W-1:0] rd_f, fl;
  logic [CORR_W-1:0] rd_c, cl;
  logic [UNC_W-1:0] rd_u, ul;
  logic [STAT_W-1:0] status, running, worst;
  logic [31:0] rc, ru;
  logic start, done_c, done_u, a_neg;
  logic [39:0] am, dd;
  logic signed [31:0] res_c, res_u;

  assign {rd_f, rd_c, rd_u} = rdata;

  // Clamp the point count to between 2 and the table size.
  always_comb begin
    if (point_count < CFG_W'(2)) begin
      n = CNT_W'(2);
    end else if (32'(point_count) > 32'(MAX_POINTS)) begin
      n = CNT_W'(MAX_POINTS);
    end else begin
      n = CNT_W'(point_count);
    end
  end

  plcl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk(clk), .we(we), .waddr(ADDR_W'(cur.idx)),
    .wdata({cur.pf, cur.pc, cur.pu}), .raddr(raddr), .rdata(rdata)
  );

  assign pop = (st == S_IDLE) && !q_empty;
  assign we = (st == S_WRITE);
  assign start = (st == S_PAIR) && (rd_f > fl);
  assign a_neg = (cur.qf < fl);
  assign am = a_neg ? (fl - cur.qf) : (cur.qf - fl);
  assign dd = rd_f - fl;
  assign worst = (status > running) ? status : running;

  always_comb begin
    unique case (st)
      S_IDLE: raddr = (head.op == OP_LOAD) ? ADDR_W'(head.idx - IDX_W'(1)) : '0;
      S_SCAN: raddr = ADDR_W'(i + CNT_W'(1));
      S_RDL: raddr = l;
      S_RDR: raddr = ADDR_W'(l + ADDR_W'(1));
      default: raddr = '0;
    endcase
  end

  plcl_muldiv u_md_c (
    .clk(clk), .rst(rst), .start(start), .a_neg(a_neg), .am(am),
    .vl($signed(cl)), .vr($signed(rd_c)), .d(dd), .done(done_c), .res(res_c)
  );

  plcl_muldiv u_md_u (
    .clk(clk), .rst(rst), .start(start), .a_neg(a_neg), .am(am),
    .vl($signed({1'b0, ul})), .vr($signed({1'b0, rd_u})), .d(dd),
    .done(done_u), .res(res_u)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      running <= ST_APPLIED;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && st != S_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= head;
            rc <= '0;
            ru <= '0;
            if (head.op == OP_LOAD) begin
              if (head.early) begin
                status <= ST_LOAD_REJ;
                st <= S_OUT;
              end else if (head.idx == '0) begin
                st <= S_WRITE;
              end else begin
                st <= S_LCHK;
              end
            end else if (head.early) begin
              status <= ST_INVALID;
              st <= S_OUT;
            end else begin
              i <= '0;
              st <= S_SCAN;
            end
          end
        end
        S_LCHK: begin
          if (cur.pf <= rd_f) begin
            status <= ST_LOAD_REJ;
            st <= S_OUT;
          end else begin
            st <= S_WRITE;
          end
        end
        S_WRITE: begin
          status <= ST_LOAD_OK;
          st <= S_OUT;
        end
        S_SCAN: begin
          if (rd_f >= cur.qf) begin
            if (rd_f == cur.qf) begin
              status <= ST_APPLIED;
              rc <= rd_c;
              ru <= {1'b0, rd_u};
              st <= S_OUT;
            end else if (i == '0) begin
              l <= '0;
              status <= extrap_en ? ST_EXTRAP : ST_INVALID;
              st <= extrap_en ? S_RDL : S_OUT;
            end else begin
              l <= ADDR_W'(i - CNT_W'(1));
              status <= ST_INTERP;
              st <= S_RDL;
            end
          end else if (i + CNT_W'(1) == n) begin
            l <= ADDR_W'(n - CNT_W'(2));
            status <= extrap_en ? ST_EXTRAP : ST_INVALID;
            st <= extrap_en ? S_RDL : S_OUT;
          end else begin
            i <= i + CNT_W'(1);
          end
        end
        S_RDL: st <= S_RDR;
        S_RDR: begin
          fl <= rd_f;
          cl <= rd_c;
          ul <= rd_u;
          st <= S_PAIR;
        end
        S_PAIR: begin
          if (rd_f <= fl) begin
            status <= ST_INVALID;
            st <= S_OUT;
          end else begin
            st <= S_ARITH;
          end
        end
        S_ARITH: begin
          if (done_c && done_u) begin
            rc <= res_c;
            ru <= res_u;
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            correction <= rc;
            uncertainty <= ru;
            sample_status <= status;
            if (cur.op == OP_LOAD) begin
              grid_worst_status <= running;
              grid_end <= 1'b0;
            end else begin
              grid_worst_status <= worst;
              grid_end <= cur.last;
              running <= cur.last ? ST_APPLIED : worst;
            end
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_load_no_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && (sample_status == ST_LOAD_OK || sample_status == ST_LOAD_REJ)
    |-> !grid_end) else $error("grid end flagged on a load result");

  a_worst_covers: assert property (@(posedge clk) disable iff (rst)
    result_valid && sample_status >= ST_APPLIED && sample_status <= ST_INVALID
    |-> grid_worst_status >= sample_status)
    else $error("grid worst status below sample status");

  a_running_range: assert property (@(posedge clk) disable iff (rst)
    running >= ST_APPLIED && running <= ST_INVALID)
    else $error("running worst status out of range");

  a_arith_done: assert property (@(posedge clk) disable iff (rst)
    done_c |-> st == S_ARITH) else $error("arithmetic finished outside wait state");
endmodule

### rtl/piecewise_linear_calibration_lookup.sv
// Top level of the piecewise-linear calibration lookup.
//
// Input channel (item_valid / item_stall): each item either loads one
// calibration point (op = load) or evaluates a query frequency (op = eval).
// An item is taken on a clock edge with item_valid high and item_stall low.
// Result channel (result_valid / result_stall): exactly one result per item,
// in order, held stable while result_stall is high.
// Configuration: cfg_write with cfg_index 0 sets point_count, index 1 sets
// extrapolation_enable; write only while the block is idle.
// Flow: the front end queues up to two items; the back end handles one at
// a time. A load checks the stored previous point unless its index is 0,
// then writes; an exact hit or an invalid query is settled in a linear
// search, one table read per point; an interpolated or extrapolated query
// adds a 32-step shift-add multiply and a 72-step restoring divide.
// Reset (rst, synchronous) empties the queue, drops any result in flight and
// sets point_count = 2, extrapolation off, running grid status to applied.
// Table contents are not cleared; load every point in use before reading.
// A stalled receiver holds the result register; the back end then waits
// and the queue fills until item_stall rises.
module piecewise_linear_calibration_lookup #(
  parameter int MAX_POINTS = plcl_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [plcl_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          op,
  input  logic [plcl_pkg::IDX_W-1:0]    point_index,
  input  logic [plcl_pkg::FREQ_W-1:0]   point_frequency,
  input  logic signed [31:0]            point_correction,
  input  logic [plcl_pkg::UNC_W-1:0]    point_uncertainty,
  input  logic [plcl_pkg::FREQ_W-1:0]   query_frequency,
  input  logic                          grid_last,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [31:0]            correction,
  output logic signed [31:0]            uncertainty,
  output logic [plcl_pkg::STAT_W-1:0]   sample_status,
  output logic [plcl_pkg::STAT_W-1:0]   grid_worst_status,
  output logic                          grid_end
);
  import plcl_pkg::*;

  logic [CFG_W-1:0] point_count;
  logic extrap_en;
  logic push, pop, q_full, q_empty;
  item_t push_item, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CFG_W'(2);
      extrap_en <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data;
        CFG_EXTRAP_EN: extrap_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  plcl_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .item_valid(item_valid), .item_stall(item_stall), .op(op),
    .point_index(point_index), .point_frequency(point_frequency),
    .point_correction(point_correction), .point_uncertainty(point_uncertainty),
    .query_frequency(query_frequency), .grid_last(grid_last),
    .q_full(q_full), .push(push), .push_item(push_item)
  );

  plcl_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .pop(pop),
    .full(q_full), .empty(q_empty), .head(head)
  );

  plcl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst(rst), .point_count(point_count), .extrap_en(extrap_en),
    .q_empty(q_empty), .head(head), .pop(pop),
    .result_valid(result_valid), .result_stall(result_stall),
    .correction(correction), .uncertainty(uncertainty),
    .sample_status(sample_status), .grid_worst_status(grid_worst_status),
    .grid_end(grid_end)
  );
endmodule
